// ----- sv/radar_motion_feature_extractor_assert.svh -----
// Assertion macros shared by the checker files of the radar feature block.
// Needs nothing else; every macro samples on i_clk and is off while i_rst_n is low.
`ifndef RADAR_MOTION_FEATURE_EXTRACTOR_ASSERT_SVH
`define RADAR_MOTION_FEATURE_EXTRACTOR_ASSERT_SVH

// Same-cycle implication.
`define RMFE_ASSERT_IMPLY(LBL, A, C) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (A) |-> (C)) \
        else $error("rmfe check failed");

// Next-cycle implication.
`define RMFE_ASSERT_NEXT(LBL, A, C) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (A) |=> (C)) \
        else $error("rmfe check failed");

`endif

// ----- sv/rmfe_pkg.sv -----
// Shared constants, types and helpers for the radar motion feature extractor.
// No dependencies.
`timescale 1ns / 1ps

package rmfe_pkg;

    localparam int HISTORY_DEPTH = 32;
    localparam int AVERAGE_TAPS  = 5;
    localparam int TREND_SPAN    = 5;
    localparam int SCALE_STEPS   = 15;   // quotient bits of one scaling division
    localparam int SPREAD_BITS   = 30;
    localparam logic [14:0] Q_MAX = 15'd32767;

    // floor(m / 5) for m < 2^18: 52429 * 5 = 2^18 + 1
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam int          DIV5_SHIFT = 18;

    localparam logic [15:0] RST_DIST_FS   = 16'd8000;
    localparam logic [14:0] RST_VEL_FS    = 15'd5000;
    localparam logic [7:0]  RST_EN_FS     = 8'd100;
    localparam logic [14:0] RST_BREATH_E  = 15'd9830;
    localparam logic [14:0] RST_BREATH_V  = 15'd6554;

    typedef enum logic [2:0] {
        REG_DIST_FS  = 3'd0,
        REG_VEL_FS   = 3'd1,
        REG_EN_FS    = 3'd2,
        REG_BREATH_E = 3'd3,
        REG_BREATH_V = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN,      // scaling divisions and history pass side by side
        ST_WIN,
        ST_SUM,
        ST_MEAN,
        ST_PRODUCT,
        ST_NUMER,
        ST_VDIV,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic start;
        logic run;
        logic win;
        logic sum;
        logic mean;
        logic product;
        logic numer;
        logic vdiv;
        logic write;
    } t_ctrl;

    // Truncating divide by five; both the window taps and the trend span are five.
    function automatic logic [14:0] div_by_five(input logic [17:0] m);
        logic [33:0] p;
        p = 34'(m) * 34'(DIV5_RECIP);
        return p[DIV5_SHIFT +: 15];
    endfunction

endpackage

// ----- sv/radar_motion_feature_extractor.sv -----
// Radar motion feature extractor: top level, single module.
// Depends on rmfe_pkg.
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Usage
//  Input channel: i_in_valid / o_in_stall carries one radar report (distance,
//   velocity, energy, target count). A request is taken when valid is high
//   and stall is low; stall is high while a report is being worked on.
//  Output channel: o_out_valid / i_out_stall carries one result per report.
//   The result sits in an output register; a stalled result holds steady, and
//   the next report is taken meanwhile. Only the final history write waits for
//   the output register to free up.
//  Sequence: from the accepting edge the three scaling divisions run one after
//   another on the shared divider, beside the history read pass; then come the
//   window update, averaging and products, the numerator load, the variance
//   divider (one quotient bit a cycle) and the write state.
//   A new report is taken only once the previous one has left the write
//   state; the variance divider and the shared scaling divider take most
//   of the time between reports.
//  Config: APB write while idle; pready is tied high; reads return values.
//  Reset (synchronous, active low): registers to defaults, windows zero,
//   history empty. History memory is not cleared; only filled entries are read.
// ---------------------------------------------------------------------------

module radar_motion_feature_extractor #(
    parameter int HISTORY_DEPTH = rmfe_pkg::HISTORY_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // report in
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_distance_mm,
    input  logic signed [15:0] i_velocity_mm_s,
    input  logic [7:0]         i_energy_level,
    input  logic [7:0]         i_target_total,
    // result out
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [14:0]        o_distance_average,
    output logic signed [15:0] o_velocity_average,
    output logic [14:0]        o_energy_average,
    output logic [29:0]        o_distance_spread,
    output logic signed [15:0] o_energy_slope,
    output logic [14:0]        o_motion_strength,
    output logic [7:0]         o_target_total_out,
    output logic               o_breathing_seen
);

    localparam int AW   = $clog2(HISTORY_DEPTH);
    localparam int NW   = $clog2(HISTORY_DEPTH + 1);
    localparam int S1W  = 15 + NW;
    localparam int SW2  = 30 + NW;
    localparam int NUMW = 30 + 2 * NW;
    localparam int H    = SW2 / 2;
    localparam int HW   = SW2 - H;
    localparam int QW   = 2 * NW;
    localparam int TAPS = rmfe_pkg::AVERAGE_TAPS;
    localparam int WPW  = $clog2(TAPS);
    localparam int SB   = rmfe_pkg::SPREAD_BITS;
    localparam int VCW  = $clog2(SB);

    // ---------------- configuration registers ----------------
    logic [15:0] r_dist_fs;
    logic [14:0] r_vel_fs;
    logic [7:0]  r_en_fs;
    logic [14:0] r_breath_e;
    logic [14:0] r_breath_v;
    rmfe_pkg::t_reg_idx reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = rmfe_pkg::t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_fs  <= rmfe_pkg::RST_DIST_FS;
            r_vel_fs   <= rmfe_pkg::RST_VEL_FS;
            r_en_fs    <= rmfe_pkg::RST_EN_FS;
            r_breath_e <= rmfe_pkg::RST_BREATH_E;
            r_breath_v <= rmfe_pkg::RST_BREATH_V;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                rmfe_pkg::REG_DIST_FS:  r_dist_fs  <= pwdata[15:0];
                rmfe_pkg::REG_VEL_FS:   r_vel_fs   <= pwdata[14:0];
                rmfe_pkg::REG_EN_FS:    r_en_fs    <= pwdata[7:0];
                rmfe_pkg::REG_BREATH_E: r_breath_e <= pwdata[14:0];
                rmfe_pkg::REG_BREATH_V: r_breath_v <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            rmfe_pkg::REG_DIST_FS:  prdata = {16'd0, r_dist_fs};
            rmfe_pkg::REG_VEL_FS:   prdata = {17'd0, r_vel_fs};
            rmfe_pkg::REG_EN_FS:    prdata = {24'd0, r_en_fs};
            rmfe_pkg::REG_BREATH_E: prdata = {17'd0, r_breath_e};
            rmfe_pkg::REG_BREATH_V: prdata = {17'd0, r_breath_v};
            default:                prdata = 32'd0;
        endcase
    end

    // ---------------- control ----------------
    rmfe_pkg::t_state r_state, n_state;
    rmfe_pkg::t_ctrl  ctl;
    logic r_sdone, r_pdone;
    logic [VCW-1:0] r_vcnt;
    logic r_out_valid;
    logic out_free, write_fire, in_acc;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_acc     = i_in_valid && (r_state == rmfe_pkg::ST_IDLE);
    assign write_fire = ctl.write && out_free;
    assign o_in_stall = (r_state != rmfe_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmfe_pkg::ST_IDLE:    if (i_in_valid) n_state = rmfe_pkg::ST_RUN;
            rmfe_pkg::ST_RUN:     if (r_sdone && r_pdone) n_state = rmfe_pkg::ST_WIN;
            rmfe_pkg::ST_WIN:     n_state = rmfe_pkg::ST_SUM;
            rmfe_pkg::ST_SUM:     n_state = rmfe_pkg::ST_MEAN;
            rmfe_pkg::ST_MEAN:    n_state = rmfe_pkg::ST_PRODUCT;
            rmfe_pkg::ST_PRODUCT: n_state = rmfe_pkg::ST_NUMER;
            rmfe_pkg::ST_NUMER:   n_state = rmfe_pkg::ST_VDIV;
            rmfe_pkg::ST_VDIV:    if (r_vcnt == VCW'(SB - 1)) n_state = rmfe_pkg::ST_WRITE;
            rmfe_pkg::ST_WRITE:   if (out_free) n_state = rmfe_pkg::ST_IDLE;
            default:              n_state = rmfe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctl         = '0;
        ctl.start   = in_acc;
        ctl.run     = (r_state == rmfe_pkg::ST_RUN);
        ctl.win     = (r_state == rmfe_pkg::ST_WIN);
        ctl.sum     = (r_state == rmfe_pkg::ST_SUM);
        ctl.mean    = (r_state == rmfe_pkg::ST_MEAN);
        ctl.product = (r_state == rmfe_pkg::ST_PRODUCT);
        ctl.numer   = (r_state == rmfe_pkg::ST_NUMER);
        ctl.vdiv    = (r_state == rmfe_pkg::ST_VDIV);
        ctl.write   = (r_state == rmfe_pkg::ST_WRITE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rmfe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- input capture ----------------
    logic [15:0] r_dist, r_vmag;
    logic        r_vneg;
    logic [7:0]  r_energy, r_targets;
    logic [15:0] v_raw;

    assign v_raw = i_velocity_mm_s;

    always_ff @(posedge i_clk) begin
        if (ctl.start) begin
            r_dist    <= i_distance_mm;
            r_vneg    <= v_raw[15];
            r_vmag    <= v_raw[15] ? (~v_raw + 16'd1) : v_raw;
            r_energy  <= i_energy_level;
            r_targets <= i_target_total;
        end
    end

    // ---------------- scaling divider (shared by three channels) ----------------
    // Value < full scale gives a 15-bit quotient of value*2^15/fs; otherwise saturate.
    logic [1:0]  r_ssel;
    logic [3:0]  r_scnt;
    logic [15:0] r_srem;
    logic [14:0] r_squo;
    logic        r_ssat;
    logic [15:0] s_mag, s_fs;
    logic [16:0] s_t;
    logic        s_ge;
    logic [15:0] s_rem_nx;
    logic [14:0] s_quo_nx, s_res;
    logic [14:0] r_sd, r_se;
    logic signed [15:0] r_sv;

    always_comb begin
        case (r_ssel)
            2'd0: begin
                s_mag = r_dist;
                s_fs  = (r_dist_fs == 16'd0) ? 16'd1 : r_dist_fs;
            end
            2'd1: begin
                s_mag = r_vmag;
                s_fs  = (r_vel_fs == 15'd0) ? 16'd1 : {1'b0, r_vel_fs};
            end
            default: begin
                s_mag = {8'd0, r_energy};
                s_fs  = (r_en_fs == 8'd0) ? 16'd1 : {8'd0, r_en_fs};
            end
        endcase
        s_t      = {r_srem, 1'b0};
        s_ge     = (s_t >= {1'b0, s_fs});
        s_rem_nx = s_ge ? 16'(s_t - {1'b0, s_fs}) : s_t[15:0];
        s_quo_nx = {r_squo[13:0], s_ge};
        s_res    = r_ssat ? rmfe_pkg::Q_MAX : s_quo_nx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ssel  <= 2'd0;
            r_scnt  <= 4'd0;
            r_sdone <= 1'b0;
        end else if (ctl.start) begin
            r_ssel  <= 2'd0;
            r_scnt  <= 4'd0;
            r_sdone <= 1'b0;
        end else if (ctl.run && !r_sdone) begin
            if (r_scnt == 4'd0) begin
                r_scnt <= 4'd1;
            end else if (r_scnt == 4'(rmfe_pkg::SCALE_STEPS)) begin
                r_scnt <= 4'd0;
                if (r_ssel == 2'd2) begin
                    r_sdone <= 1'b1;
                end else begin
                    r_ssel <= r_ssel + 2'd1;
                end
            end else begin
                r_scnt <= r_scnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.run && !r_sdone) begin
            if (r_scnt == 4'd0) begin
                r_srem <= s_mag;
                r_squo <= 15'd0;
                r_ssat <= (s_mag >= s_fs);
            end else begin
                r_srem <= s_rem_nx;
                r_squo <= s_quo_nx;
                if (r_scnt == 4'(rmfe_pkg::SCALE_STEPS)) begin
                    case (r_ssel)
                        2'd0:    r_sd <= s_res;
                        2'd1:    r_sv <= r_vneg ? -$signed({1'b0, s_res}) : $signed({1'b0, s_res});
                        default: r_se <= s_res;
                    endcase
                end
            end
        end
    end

    // ---------------- history memory and read pass ----------------
    // {distance average, energy average} per entry. Read data is used only in the
    // pass, the write comes only at the end of the item, so they never collide.
    logic [29:0]   mem [HISTORY_DEPTH];
    logic [29:0]   r_mem_q;
    logic [AW-1:0] r_head;
    logic [NW-1:0] r_fill;
    logic [NW-1:0] r_pidx;
    logic          r_pissue, r_p1, r_p2;
    logic [AW-1:0] r_p1idx;
    logic [29:0]   r_sq;
    logic [S1W-1:0] r_s1;
    logic [SW2-1:0] r_s2;
    logic [17:0]   r_recent, r_older;
    logic [14:0]   p_d, p_e;
    logic [AW:0]   k_raw, k_pos;
    logic [14:0]   r_mean_d, r_mean_e;

    always_ff @(posedge i_clk) begin
        r_mem_q <= mem[r_pidx[AW-1:0]];
        if (write_fire) begin
            mem[r_head] <= {r_mean_d, r_mean_e};
        end
    end

    assign p_d   = r_mem_q[29:15];
    assign p_e   = r_mem_q[14:0];
    // age of the entry: 0 is the newest
    assign k_raw = {1'b0, r_head} - {1'b0, r_p1idx} - (AW + 1)'(1);
    assign k_pos = k_raw[AW] ? (k_raw + (AW + 1)'(HISTORY_DEPTH)) : k_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pissue <= 1'b0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_pdone  <= 1'b0;
        end else if (ctl.start) begin
            r_pissue <= (r_fill != '0);
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
            r_pdone  <= 1'b0;
        end else if (ctl.run) begin
            if (r_pissue && (r_pidx == r_fill - NW'(1))) begin
                r_pissue <= 1'b0;
            end
            r_p1    <= r_pissue;
            r_p2    <= r_p1;
            r_pdone <= r_pdone || (!r_pissue && !r_p1 && !r_p2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.start) begin
            r_pidx   <= '0;
            r_s1     <= '0;
            r_s2     <= '0;
            r_recent <= '0;
            r_older  <= '0;
        end else if (ctl.run) begin
            if (r_pissue) begin
                r_pidx <= r_pidx + NW'(1);
            end
            r_p1idx <= r_pidx[AW-1:0];
            if (r_p1) begin
                r_sq <= p_d * p_d;
                r_s1 <= r_s1 + S1W'(p_d);
                if (k_pos < (AW + 1)'(rmfe_pkg::TREND_SPAN)) begin
                    r_recent <= r_recent + 18'(p_e);
                end else if (k_pos < (AW + 1)'(2 * rmfe_pkg::TREND_SPAN)) begin
                    r_older <= r_older + 18'(p_e);
                end
            end
            if (r_p2) begin
                r_s2 <= r_s2 + SW2'(r_sq);
            end
        end
    end

    // ---------------- moving average windows ----------------
    logic [14:0]        r_dwin [TAPS];
    logic signed [15:0] r_vwin [TAPS];
    logic [14:0]        r_ewin [TAPS];
    logic [WPW-1:0]     r_wpos;
    logic [17:0]        r_sum_d, r_sum_e;
    logic signed [18:0] r_sum_v;
    logic [17:0]        sum_d, sum_e;
    logic signed [18:0] sum_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_dwin[i] <= '0;
                r_vwin[i] <= '0;
                r_ewin[i] <= '0;
            end
            r_wpos <= '0;
        end else if (ctl.win) begin
            for (int i = 0; i < TAPS; i++) begin
                if (r_wpos == WPW'(i)) begin
                    r_dwin[i] <= r_sd;
                    r_vwin[i] <= r_sv;
                    r_ewin[i] <= r_se;
                end
            end
            r_wpos <= (r_wpos == WPW'(TAPS - 1)) ? '0 : r_wpos + WPW'(1);
        end
    end

    always_comb begin
        sum_d = '0;
        sum_e = '0;
        sum_v = '0;
        for (int i = 0; i < TAPS; i++) begin
            sum_d = sum_d + 18'(r_dwin[i]);
            sum_e = sum_e + 18'(r_ewin[i]);
            sum_v = sum_v + 19'(r_vwin[i]);
        end
    end

    // ---------------- averages, trend, products ----------------
    logic signed [15:0] r_mean_v;
    logic signed [15:0] r_slope;
    logic [17:0]        v_mag, t_mag;
    logic [14:0]        v_q, t_q;
    logic signed [18:0] t_diff;
    logic [14:0]        v_abs;
    logic [NW+H-1:0]    r_pl;
    logic [NW+HW-1:0]   r_ph;
    logic [NUMW-1:0]    r_s1sq;
    logic [QW-1:0]      r_nsq;
    logic [14:0]        r_motion;
    logic               r_breath;
    logic [29:0]        mot_p;
    logic [NUMW-1:0]    numer;

    assign v_mag  = r_sum_v[18] ? 18'(-r_sum_v) : 18'(r_sum_v);
    assign v_q    = rmfe_pkg::div_by_five(v_mag);
    assign t_diff = $signed({1'b0, r_recent}) - $signed({1'b0, r_older});
    assign t_mag  = t_diff[18] ? 18'(-t_diff) : 18'(t_diff);
    assign t_q    = rmfe_pkg::div_by_five(t_mag);
    assign v_abs  = r_mean_v[15] ? 15'(-r_mean_v) : r_mean_v[14:0];
    assign mot_p  = r_mean_e * v_abs;
    assign numer  = (NUMW'(r_ph) << H) + NUMW'(r_pl) - r_s1sq;

    always_ff @(posedge i_clk) begin
        if (ctl.sum) begin
            r_sum_d <= sum_d;
            r_sum_e <= sum_e;
            r_sum_v <= sum_v;
        end
        if (ctl.mean) begin
            r_mean_d <= rmfe_pkg::div_by_five(r_sum_d);
            r_mean_e <= rmfe_pkg::div_by_five(r_sum_e);
            r_mean_v <= r_sum_v[18] ? -$signed({1'b0, v_q}) : $signed({1'b0, v_q});
            if (r_fill >= NW'(2 * rmfe_pkg::TREND_SPAN)) begin
                r_slope <= t_diff[18] ? -$signed({1'b0, t_q}) : $signed({1'b0, t_q});
            end else begin
                r_slope <= '0;
            end
        end
        if (ctl.product) begin
            r_pl     <= r_fill * r_s2[H-1:0];
            r_ph     <= r_fill * r_s2[SW2-1:H];
            r_s1sq   <= r_s1 * r_s1;
            r_nsq    <= r_fill * r_fill;
            r_motion <= mot_p[29:15];
            r_breath <= (r_fill >= NW'(2)) && (r_mean_e < r_breath_e) && (v_abs < r_breath_v);
        end
    end

    // ---------------- variance divider: one quotient bit per cycle ----------------
    // quotient is known to fit 30 bits, so the remainder starts at numer >> 30
    logic [QW-1:0] r_vrem;
    logic [SB-1:0] r_vlow, r_vq;
    logic [QW:0]   v_t;
    logic          v_ge;

    assign v_t  = {r_vrem, r_vlow[SB-1]};
    assign v_ge = (v_t >= {1'b0, r_nsq});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
        end else if (ctl.numer) begin
            r_vcnt <= '0;
        end else if (ctl.vdiv) begin
            r_vcnt <= r_vcnt + VCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.numer) begin
            r_vrem <= numer[NUMW-1:SB];
            r_vlow <= numer[SB-1:0];
            r_vq   <= '0;
        end else if (ctl.vdiv) begin
            r_vrem <= v_ge ? QW'(v_t - {1'b0, r_nsq}) : v_t[QW-1:0];
            r_vlow <= {r_vlow[SB-2:0], 1'b0};
            r_vq   <= {r_vq[SB-2:0], v_ge};
        end
    end

    // ---------------- history pointers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (write_fire) begin
            r_head <= (r_head == AW'(HISTORY_DEPTH - 1)) ? '0 : r_head + AW'(1);
            if (r_fill != NW'(HISTORY_DEPTH)) begin
                r_fill <= r_fill + NW'(1);
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (write_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (write_fire) begin
            o_distance_average <= r_mean_d;
            o_velocity_average <= r_mean_v;
            o_energy_average   <= r_mean_e;
            o_distance_spread  <= (r_fill >= NW'(2)) ? r_vq : '0;
            o_energy_slope     <= r_slope;
            o_motion_strength  <= r_motion;
            o_target_total_out <= r_targets;
            o_breathing_seen   <= r_breath;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/rmfe_checker.sv -----
// Port-level checker for the radar motion feature extractor, bound to the top.
// Depends on radar_motion_feature_extractor_assert.svh.
`timescale 1ns / 1ps
`include "radar_motion_feature_extractor_assert.svh"

module rmfe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [14:0]        o_energy_average,
    input logic [29:0]        o_distance_spread,
    input logic signed [15:0] o_energy_slope,
    input logic [14:0]        o_motion_strength,
    input logic [7:0]         o_target_total_out
);

    // part of the result payload that must hold while stalled
    logic [53:0] held_bits;

    assign held_bits = {o_distance_spread, o_energy_slope, o_target_total_out};

    // one report in flight: a taken request closes the input
    `RMFE_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall)

    `RMFE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(held_bits))

    // |velocity average| < 1.0, so the product never exceeds the energy term
    `RMFE_ASSERT_IMPLY(a_motion_bound, o_out_valid, o_motion_strength <= o_energy_average)

endmodule

bind radar_motion_feature_extractor rmfe_checker u_rmfe_checker (.*);

// ----- verif/radar_motion_feature_extractor_test.sv -----
// Self-checking testbench for radar_motion_feature_extractor: random and directed reports,
// APB register writes between phases, scoreboard against an in-bench predictor.
// Depends on rmfe_pkg and the RTL top level.
`timescale 1ns / 1ps

module radar_motion_feature_extractor_test;

    localparam int HIST = rmfe_pkg::HISTORY_DEPTH;
    localparam int TAPS = rmfe_pkg::AVERAGE_TAPS;

    typedef struct packed {
        logic [15:0]        distance;
        logic signed [15:0] vel;
        logic [7:0]         energy;
        logic [7:0]         targets;
    } t_report;

    typedef struct packed {
        logic [14:0]        d_avg;
        logic signed [15:0] v_avg;
        logic [14:0]        e_avg;
        logic [29:0]        spread;
        logic signed [15:0] slope;
        logic [14:0]        strength;
        logic [7:0]         targets;
        logic               breathing;
    } t_features;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [15:0] i_distance_mm = '0;
    logic signed [15:0] i_velocity_mm_s = '0;
    logic [7:0] i_energy_level = '0;
    logic [7:0] i_target_total = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [14:0] o_distance_average;
    logic signed [15:0] o_velocity_average;
    logic [14:0] o_energy_average;
    logic [29:0] o_distance_spread;
    logic signed [15:0] o_energy_slope;
    logic [14:0] o_motion_strength;
    logic [7:0] o_target_total_out;
    logic o_breathing_seen;

    radar_motion_feature_extractor dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state: mirrors of the config registers, windows and history ring.
    longint dist_fs = rmfe_pkg::RST_DIST_FS, vel_fs = rmfe_pkg::RST_VEL_FS;
    longint en_fs = rmfe_pkg::RST_EN_FS;
    longint breath_e = rmfe_pkg::RST_BREATH_E, breath_v = rmfe_pkg::RST_BREATH_V;
    longint dist_win[TAPS], vel_win[TAPS], en_win[TAPS];
    int win_pos = 0;
    longint dist_hist[HIST], en_hist[HIST];
    int hist_head = 0, hist_fill = 0;

    t_report pending_reports[$];
    t_features expected_features[$];
    int idle_pct = 0, stall_pct = 0;
    int mismatches = 0;
    bit in_taken = 1'b0;

    function automatic longint clamp_q15(longint v);
        if (v > 32767) return 32767;
        if (v < -32767) return -32767;
        return v;
    endfunction

    // SV integer division truncates toward zero, as needed here.
    function automatic longint to_q15(longint v, longint fs);
        return clamp_q15((v * 32768) / (fs == 0 ? 1 : fs));
    endfunction

    function automatic t_features extract_features(t_report r);
        t_features f;
        longint d_avg, v_avg, e_avg, v_abs, s1, s2, recent, older, sum_d, sum_v, sum_e;
        longint slope, spread;
        int n, idx;
        dist_win[win_pos] = to_q15(longint'(r.distance), dist_fs);
        vel_win[win_pos]  = to_q15(longint'(r.vel), vel_fs);
        en_win[win_pos]   = to_q15(longint'(r.energy), en_fs);
        win_pos = (win_pos + 1) % TAPS;
        sum_d = 0; sum_v = 0; sum_e = 0;
        for (int i = 0; i < TAPS; i++) begin
            sum_d += dist_win[i]; sum_v += vel_win[i]; sum_e += en_win[i];
        end
        d_avg = sum_d / TAPS; v_avg = sum_v / TAPS; e_avg = sum_e / TAPS;
        v_abs = v_avg < 0 ? -v_avg : v_avg;
        n = hist_fill;
        spread = 0; slope = 0;
        if (n >= 2) begin
            s1 = 0; s2 = 0;
            for (int i = 0; i < n; i++) begin
                s1 += dist_hist[i]; s2 += dist_hist[i] * dist_hist[i];
            end
            spread = (n * s2 - s1 * s1) / (n * n);
        end
        if (n >= 10) begin
            recent = 0; older = 0;
            for (int i = 0; i < 10; i++) begin
                idx = (hist_head + HIST - 1 - i) % HIST;
                if (i < 5) recent += en_hist[idx];
                else older += en_hist[idx];
            end
            slope = clamp_q15((recent - older) / 5);
        end
        f.d_avg = d_avg[14:0];
        f.v_avg = v_avg[15:0];
        f.e_avg = e_avg[14:0];
        f.spread = spread[29:0];
        f.slope = slope[15:0];
        f.strength = 15'((e_avg * v_abs) >> 15);
        f.targets = r.targets;
        f.breathing = (n >= 2) && (e_avg < breath_e) && (v_abs < breath_v);
        dist_hist[hist_head] = d_avg;
        en_hist[hist_head] = e_avg;
        hist_head = (hist_head + 1) % HIST;
        if (hist_fill < HIST) hist_fill++;
        return f;
    endfunction

    // Driver: payload and valid change on the falling edge only.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                // previous request (if any) was taken at the last rising edge
                if (pending_reports.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    t_report r;
                    r = pending_reports.pop_front();
                    i_distance_mm   <= r.distance;
                    i_velocity_mm_s <= r.vel;
                    i_energy_level  <= r.energy;
                    i_target_total  <= r.targets;
                    i_in_valid      <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Accepted requests feed the predictor; accepted results are checked.
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            t_report r;
            r = '{i_distance_mm, i_velocity_mm_s, i_energy_level, i_target_total};
            expected_features.push_back(extract_features(r));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_features got, want;
            got = '{o_distance_average, o_velocity_average, o_energy_average,
                    o_distance_spread, o_energy_slope, o_motion_strength,
                    o_target_total_out, o_breathing_seen};
            if (expected_features.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result: %p", got);
            end else begin
                want = expected_features.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    task automatic write_reg(rmfe_pkg::t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            rmfe_pkg::REG_DIST_FS:  dist_fs  = value[15:0];
            rmfe_pkg::REG_VEL_FS:   vel_fs   = value[14:0];
            rmfe_pkg::REG_EN_FS:    en_fs    = value[7:0];
            rmfe_pkg::REG_BREATH_E: breath_e = value[14:0];
            rmfe_pkg::REG_BREATH_V: breath_v = value[14:0];
            default: ;
        endcase
    endtask

    task automatic queue_report(logic [15:0] d, logic [15:0] v, logic [7:0] e, logic [7:0] t);
        pending_reports.push_back('{d, v, e, t});
    endtask

    // Mostly radar-like values near the configured scales, some full-range noise.
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(3) == 0)
                queue_report(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            else
                queue_report(16'($urandom_range(dist_fs)),
                             16'($urandom_range(2 * vel_fs) - vel_fs),
                             8'($urandom_range(en_fs)), 8'($urandom_range(8)));
        end
    endtask

    task automatic drain;
        while (pending_reports.size() > 0 || i_in_valid || expected_features.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        for (int i = 0; i < TAPS; i++) begin
            dist_win[i] = 0; vel_win[i] = 0; en_win[i] = 0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes at reset scaling, then saturation cases.
        queue_report(16'd0, 16'sh0000, 8'd0, 8'd0);
        queue_report(16'hFFFF, 16'sh7FFF, 8'hFF, 8'hFF);
        queue_report(16'hFFFF, 16'sh8000, 8'hFF, 8'hAA);
        queue_report(16'd8000, -16'sd5000, 8'd100, 8'h55);
        queue_report(16'd7999, 16'sd4999, 8'd99, 8'd1);
        for (int i = 0; i < 12; i++) // builds history past the trend span
            queue_report(16'(i * 700), 16'(i * 37 - 200), 8'(i * 9), 8'(i));
        queue_report(16'd1, -16'sd1, 8'd1, 8'd2);
        queue_report(16'd0, 16'sd0, 8'd0, 8'd0);
        drain();

        // Extreme scales: full scale zero reads as one; largest scales; limits at edges.
        write_reg(rmfe_pkg::REG_DIST_FS, 32'd0);
        write_reg(rmfe_pkg::REG_VEL_FS, 32'd0);
        write_reg(rmfe_pkg::REG_EN_FS, 32'd0);
        write_reg(rmfe_pkg::REG_BREATH_E, 32'd32767);
        write_reg(rmfe_pkg::REG_BREATH_V, 32'd0);
        queue_report(16'd0, 16'sd0, 8'd0, 8'd3);
        queue_report(16'd1, -16'sd1, 8'd1, 8'd3);
        queue_report(16'd2, 16'sd1, 8'd0, 8'd3);
        drain();
        write_reg(rmfe_pkg::REG_DIST_FS, 32'hFFFF);
        write_reg(rmfe_pkg::REG_VEL_FS, 32'h7FFF);
        write_reg(rmfe_pkg::REG_EN_FS, 32'hFF);
        write_reg(rmfe_pkg::REG_BREATH_E, 32'd0);
        write_reg(rmfe_pkg::REG_BREATH_V, 32'd32767);
        queue_random(30);
        drain();

        // Random phases over idling and stall patterns and settings.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 60; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 60; end
                3: begin idle_pct = 33; stall_pct = 33; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            write_reg(rmfe_pkg::REG_DIST_FS, $urandom_range(65535, 1));
            write_reg(rmfe_pkg::REG_VEL_FS, $urandom_range(32767, 1));
            write_reg(rmfe_pkg::REG_EN_FS, $urandom_range(255, 1));
            write_reg(rmfe_pkg::REG_BREATH_E, $urandom_range(32767));
            write_reg(rmfe_pkg::REG_BREATH_V, $urandom_range(32767));
            queue_random(120);
            drain();
            idle_pct = 0; stall_pct = 0;
        end
        if (mismatches == 0 && expected_features.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Time limit for roughly 650 reports, stalls included, with wide margin.
    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/rmfe_pkg.sv
sv/radar_motion_feature_extractor.sv
sv/rmfe_checker.sv
verif/radar_motion_feature_extractor_test.sv
